// ===== sv/alarm_zone_line_classifier_top_assert.svh =====
// Assertion macros for the alarm zone line classifier.
// Used by alarm_zone_line_classifier_top; expects clk_i and rst_ni in scope.
`ifndef ALARM_ZONE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`define ALARM_ZONE_LINE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define AZLC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("azlc assertion failed");

// next-cycle implication
`define AZLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("azlc assertion failed");

`endif

// ===== sv/azlc_pkg.sv =====
// Shared types and constants for the alarm zone line classifier.
// No dependencies.
package azlc_pkg;

  localparam int unsigned ZONES  = 16;
  localparam int unsigned ZONE_W = 4;
  localparam int unsigned LVL_W  = 10;
  localparam int unsigned CNT_W  = 3;

  localparam logic [LVL_W-1:0] FULL_SCALE  = 10'd1000;
  localparam logic [LVL_W-1:0] DEF_OPEN    = 10'd700;
  localparam logic [LVL_W-1:0] DEF_TAMPER  = 10'd850;
  localparam logic [LVL_W-1:0] DEF_SHORT   = 10'd100;
  localparam logic [CNT_W-1:0] SHORT_LIMIT = 3'd3;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 3'd7;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_TAMPER = 3'd2,
    ST_OPEN   = 3'd3,
    ST_FAULT  = 3'd4
  } zone_state_e;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PROF_INSTANT  = 2'd0,
    PROF_DELAYED  = 2'd1,
    PROF_EXCLUDED = 2'd2,
    PROF_AUTO     = 2'd3
  } profile_e;

  // one row of the zone table
  typedef struct packed {
    zone_state_e      status;
    logic [CNT_W-1:0] count;
    logic             bypass;
    logic [LVL_W-1:0] open_lvl;
    logic [LVL_W-1:0] tamper_lvl;
    logic [LVL_W-1:0] short_lvl;
    profile_e         profile;
    logic             auto_en;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    status:     ST_OK,
    count:      '0,
    bypass:     1'b0,
    open_lvl:   DEF_OPEN,
    tamper_lvl: DEF_TAMPER,
    short_lvl:  DEF_SHORT,
    profile:    PROF_INSTANT,
    auto_en:    1'b0
  };

  typedef struct packed {
    op_e               op;
    logic [ZONE_W-1:0] zone;
    logic              valid;
    logic [LVL_W-1:0]  ratio;
    logic [LVL_W-1:0]  open_lvl;
    logic [LVL_W-1:0]  tamper_lvl;
    logic [LVL_W-1:0]  short_lvl;
    profile_e          profile;
    logic              auto_en;
    logic              bypass;
  } item_t;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    zone_state_e       state;
    logic              changed;
    logic              bypass;
  } result_t;

endpackage

// ===== sv/azlc_table.sv =====
// Zone table: synchronous single-port-read, single-port-write memory.
// Per-row valid bits make unwritten rows read as the reset settings. Uses azlc_pkg.
module azlc_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [azlc_pkg::ZONE_W-1:0] rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [azlc_pkg::ZONE_W-1:0] wr_addr_i,
  input  azlc_pkg::entry_t            wr_data_i,
  output azlc_pkg::entry_t            rd_data_o
);
  import azlc_pkg::*;

  entry_t             mem [ZONES];
  logic [ZONES-1:0]   vld_q;
  entry_t             rd_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : ENTRY_RST;

endmodule

// ===== sv/azlc_update.sv =====
// Row update: classifies a sample or applies a settings write to one table row.
// Purely combinational; uses azlc_pkg.
module azlc_update (
  input  azlc_pkg::item_t   item_i,
  input  azlc_pkg::entry_t  row_i,
  output azlc_pkg::entry_t  row_o,
  output logic              wr_en_o,
  output azlc_pkg::result_t res_o
);
  import azlc_pkg::*;

  logic [LVL_W-1:0] ratio_sat;
  logic [CNT_W-1:0] cnt_inc;
  logic             in_range;
  zone_state_e      cls;
  entry_t           row_d;

  assign in_range  = ({1'b0, item_i.zone} < (ZONE_W+1)'(ZONES));
  assign ratio_sat = (item_i.ratio > FULL_SCALE) ? FULL_SCALE : item_i.ratio;
  assign cnt_inc   = (row_i.count == COUNT_MAX) ? row_i.count : row_i.count + 3'd1;

  always_comb begin
    row_d = row_i;
    cls   = ST_OK;
    if (item_i.op == OP_WRITE) begin
      row_d.open_lvl   = item_i.open_lvl;
      row_d.tamper_lvl = item_i.tamper_lvl;
      row_d.short_lvl  = item_i.short_lvl;
      row_d.profile    = item_i.profile;
      row_d.auto_en    = item_i.auto_en;
      row_d.bypass     = item_i.bypass;
      row_d.count      = '0;
      cls              = row_i.status;
    end else if (!item_i.valid) begin
      cls          = ST_FAULT;
      row_d.status = ST_FAULT;
    end else begin
      if (row_i.bypass || row_i.profile == PROF_EXCLUDED) begin
        cls = ST_OK;
      end else if (ratio_sat <= row_i.short_lvl) begin
        cls = ST_SHORT;
        if (row_i.auto_en) begin
          row_d.count = cnt_inc;
          // fourth short since the last ok reading or settings write latches bypass
          if (cnt_inc > SHORT_LIMIT) begin
            row_d.bypass = 1'b1;
          end
        end
      end else if (ratio_sat >= row_i.tamper_lvl) begin
        cls = ST_TAMPER;
      end else if (ratio_sat >= row_i.open_lvl) begin
        cls = ST_OPEN;
      end else begin
        cls         = ST_OK;
        row_d.count = '0;
      end
      row_d.status = cls;
    end
  end

  always_comb begin
    res_o.zone = item_i.zone;
    if (in_range) begin
      res_o.state   = cls;
      res_o.changed = (item_i.op == OP_EVAL) && item_i.valid && (cls != row_i.status);
      res_o.bypass  = row_d.bypass;
    end else begin
      res_o.state   = ST_OK;
      res_o.changed = 1'b0;
      res_o.bypass  = 1'b0;
    end
  end

  assign row_o   = row_d;
  assign wr_en_o = in_range;

endmodule

// ===== sv/alarm_zone_line_classifier_top.sv =====
// Alarm zone line classifier, top level: transaction capture, table sequencing, result register.
// Depends on azlc_pkg, azlc_table, azlc_update and alarm_zone_line_classifier_top_assert.svh.
//
// Each transaction runs in two phases: the accept edge issues the read of the zone's row from
// the synchronous zone table, and the following cycle (busy high) updates the row and writes
// it back. The result appears on the result ports, with done_o high, for the single cycle after
// that and must be taken then; a new transaction may be started in that same cycle, but not
// while busy is high, since the table's read is registered.
// The table needs no clearing pass: rows never written read as the reset settings.
module alarm_zone_line_classifier_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [azlc_pkg::ZONE_W-1:0] zone_i,
  input  logic                        sample_valid_i,
  input  logic [azlc_pkg::LVL_W-1:0]  ratio_tenths_i,
  input  logic [azlc_pkg::LVL_W-1:0]  open_level_i,
  input  logic [azlc_pkg::LVL_W-1:0]  tamper_level_i,
  input  logic [azlc_pkg::LVL_W-1:0]  short_level_i,
  input  logic [1:0]                  zone_profile_i,
  input  logic                        auto_exclude_on_i,
  input  logic                        bypass_set_i,
  output logic                        done_o,
  output logic [azlc_pkg::ZONE_W-1:0] zone_out_o,
  output logic [2:0]                  zone_state_o,
  output logic                        state_changed_o,
  output logic                        bypassed_now_o
);
  import azlc_pkg::*;

  `include "alarm_zone_line_classifier_top_assert.svh"

  logic    accept;
  logic    busy_q, busy_d;
  logic    done_q, done_d;
  item_t   item_q, item_d;
  result_t res_q, res_d;
  entry_t  row_rd;
  entry_t  row_wr;
  logic    upd_wr_en;

  assign accept = start && !busy_q;

  always_comb begin
    item_d            = item_q;
    item_d.op         = op_e'(operation_i);
    item_d.zone       = zone_i;
    item_d.valid      = sample_valid_i;
    item_d.ratio      = ratio_tenths_i;
    item_d.open_lvl   = open_level_i;
    item_d.tamper_lvl = tamper_level_i;
    item_d.short_lvl  = short_level_i;
    item_d.profile    = profile_e'(zone_profile_i);
    item_d.auto_en    = auto_exclude_on_i;
    item_d.bypass     = bypass_set_i;
  end

  // read at accept, write back during the busy cycle: never the same edge
  azlc_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (zone_i),
    .wr_en_i   (busy_q && upd_wr_en),
    .wr_addr_i (item_q.zone),
    .wr_data_i (row_wr),
    .rd_data_o (row_rd)
  );

  azlc_update u_update (
    .item_i  (item_q),
    .row_i   (row_rd),
    .row_o   (row_wr),
    .wr_en_o (upd_wr_en),
    .res_o   (res_d)
  );

  assign busy_d = accept;
  assign done_d = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  assign busy            = busy_q;
  assign done_o          = done_q;
  assign zone_out_o      = res_q.zone;
  assign zone_state_o    = res_q.state;
  assign state_changed_o = res_q.changed;
  assign bypassed_now_o  = res_q.bypass;

  `AZLC_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy)
  `AZLC_ASSERT_NEXT(a_busy_then_done, busy, done_o && !busy)
  `AZLC_ASSERT_IMPL(a_busy_done_exclusive, busy, !done_o)
  `AZLC_ASSERT_IMPL(a_fault_not_changed, done_o && zone_state_o == ST_FAULT, !state_changed_o)

endmodule

// ===== tb/alarm_zone_line_classifier_top_tb.sv =====
// Self-checking testbench for alarm_zone_line_classifier_top: directed and random transactions.
// Depends on azlc_pkg; a per-zone predictor in a small scoreboard class checks every result.
module alarm_zone_line_classifier_top_tb;
  import azlc_pkg::*;

  // expected zone table plus the queue of results still owed by the block
  class zone_state_predictor;
    entry_t  rows[ZONES];
    result_t expected_results_q[$];
    int unsigned errors, n_items, n_writes, n_faults, n_latches, n_checked;

    function new();
      foreach (rows[i]) rows[i] = ENTRY_RST;
      errors = 0; n_items = 0; n_writes = 0; n_faults = 0; n_latches = 0; n_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_results_q.size();
    endfunction

    function void note_transaction(item_t it);
      entry_t           r;
      result_t          res;
      logic [LVL_W-1:0] ratio;
      zone_state_e      st;
      r = rows[it.zone];
      res = '0;
      res.zone = it.zone;
      ratio = (it.ratio > FULL_SCALE) ? FULL_SCALE : it.ratio;
      n_items++;
      if (it.op == OP_WRITE) begin
        r.open_lvl   = it.open_lvl;
        r.tamper_lvl = it.tamper_lvl;
        r.short_lvl  = it.short_lvl;
        r.profile    = it.profile;
        r.auto_en    = it.auto_en;
        r.bypass     = it.bypass;
        r.count      = '0;
        res.state    = r.status;
        n_writes++;
      end else if (!it.valid) begin
        r.status  = ST_FAULT;
        res.state = ST_FAULT;
        n_faults++;
      end else begin
        if (r.bypass || r.profile == PROF_EXCLUDED) begin
          st = ST_OK;
        end else if (ratio <= r.short_lvl) begin
          st = ST_SHORT;
          if (r.auto_en) begin
            if (r.count < COUNT_MAX) r.count = r.count + 1'b1;
            // fourth short since the last ok reading or settings write latches bypass
            if (r.count > SHORT_LIMIT) begin
              if (!r.bypass) n_latches++;
              r.bypass = 1'b1;
            end
          end
        end else if (ratio >= r.tamper_lvl) begin
          st = ST_TAMPER;
        end else if (ratio >= r.open_lvl) begin
          st = ST_OPEN;
        end else begin
          st = ST_OK;
          r.count = '0;
        end
        res.state   = st;
        res.changed = (st != r.status);
        r.status    = st;
      end
      res.bypass = r.bypass;
      rows[it.zone] = r;
      expected_results_q.push_back(res);
    endfunction

    function void report(string fld, int unsigned exp_v, int unsigned got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, got_v);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results_q.size() == 0) begin
        report("unexpected result, zone", 0, 32'(got.zone));
        return;
      end
      exp_r = expected_results_q.pop_front();
      n_checked++;
      if (got.zone != exp_r.zone)
        report("zone_out", 32'(exp_r.zone), 32'(got.zone));
      if (got.state != exp_r.state)
        report("zone_state", 32'(exp_r.state), 32'(got.state));
      if (got.changed != exp_r.changed)
        report("state_changed", 32'(exp_r.changed), 32'(got.changed));
      if (got.bypass != exp_r.bypass)
        report("bypassed_now", 32'(exp_r.bypass), 32'(got.bypass));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic              operation      = 1'b0;
  logic [ZONE_W-1:0] zone           = '0;
  logic              sample_valid   = 1'b0;
  logic [LVL_W-1:0]  ratio_tenths   = '0;
  logic [LVL_W-1:0]  open_level     = '0;
  logic [LVL_W-1:0]  tamper_level   = '0;
  logic [LVL_W-1:0]  short_level    = '0;
  logic [1:0]        zone_profile   = '0;
  logic              auto_exclude   = 1'b0;
  logic              bypass_set     = 1'b0;
  logic              done_o;
  logic [ZONE_W-1:0] zone_out;
  logic [2:0]        zone_state;
  logic              state_changed;
  logic              bypassed_now;

  zone_state_predictor sb;

  alarm_zone_line_classifier_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation),
    .zone_i            (zone),
    .sample_valid_i    (sample_valid),
    .ratio_tenths_i    (ratio_tenths),
    .open_level_i      (open_level),
    .tamper_level_i    (tamper_level),
    .short_level_i     (short_level),
    .zone_profile_i    (zone_profile),
    .auto_exclude_on_i (auto_exclude),
    .bypass_set_i      (bypass_set),
    .done_o            (done_o),
    .zone_out_o        (zone_out),
    .zone_state_o      (zone_state),
    .state_changed_o   (state_changed),
    .bypassed_now_o    (bypassed_now)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // results are checked before the same edge's accepted transaction is noted
  always @(posedge clk_i) begin
    result_t got;
    item_t   it;
    if (rst_ni) begin
      if (done_o) begin
        got.zone    = zone_out;
        got.state   = zone_state_e'(zone_state);
        got.changed = state_changed;
        got.bypass  = bypassed_now;
        sb.check_result(got);
      end
      if (start && !busy) begin
        it.op         = op_e'(operation);
        it.zone       = zone;
        it.valid      = sample_valid;
        it.ratio      = ratio_tenths;
        it.open_lvl   = open_level;
        it.tamper_lvl = tamper_level;
        it.short_lvl  = short_level;
        it.profile    = profile_e'(zone_profile);
        it.auto_en    = auto_exclude;
        it.bypass     = bypass_set;
        sb.note_transaction(it);
      end
    end
  end

  // fields that do not belong to the op get random values
  function automatic item_t eval_item(int unsigned z, bit v, int unsigned r);
    item_t it;
    it.op         = OP_EVAL;
    it.zone       = ZONE_W'(z);
    it.valid      = v;
    it.ratio      = LVL_W'(r);
    it.open_lvl   = LVL_W'($urandom_range(1023));
    it.tamper_lvl = LVL_W'($urandom_range(1023));
    it.short_lvl  = LVL_W'($urandom_range(1023));
    it.profile    = profile_e'($urandom_range(3));
    it.auto_en    = 1'($urandom_range(1));
    it.bypass     = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t write_item(int unsigned z, int unsigned o, int unsigned t,
                                       int unsigned s, profile_e p, bit a, bit b);
    item_t it;
    it.op         = OP_WRITE;
    it.zone       = ZONE_W'(z);
    it.valid      = 1'($urandom_range(1));
    it.ratio      = LVL_W'($urandom_range(1023));
    it.open_lvl   = LVL_W'(o);
    it.tamper_lvl = LVL_W'(t);
    it.short_lvl  = LVL_W'(s);
    it.profile    = p;
    it.auto_en    = a;
    it.bypass     = b;
    return it;
  endfunction

  task automatic send_item(item_t it);
    start        <= 1'b1;
    operation    <= it.op;
    zone         <= it.zone;
    sample_valid <= it.valid;
    ratio_tenths <= it.ratio;
    open_level   <= it.open_lvl;
    tamper_level <= it.tamper_lvl;
    short_level  <= it.short_lvl;
    zone_profile <= it.profile;
    auto_exclude <= it.auto_en;
    bypass_set   <= it.bypass;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic sender_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct[5];
    int unsigned burst_left, burst_zone, z, pick;
    item_t       it;
    idle_pct = '{0, 74, 0, 31, 74};
    sb = new();
    burst_left = 0;
    burst_zone = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: threshold boundaries on default settings, saturation, fault
    send_item(eval_item(0, 1, 500));
    send_item(eval_item(0, 1, 100));
    send_item(eval_item(0, 1, 850));
    send_item(eval_item(0, 1, 700));
    send_item(eval_item(0, 1, 1023));
    send_item(eval_item(0, 0, $urandom_range(1023)));
    send_item(eval_item(0, 1, 0));
    // auto-exclusion: fourth consecutive short latches bypass, then reads ok
    send_item(write_item(15, 1023, 1023, 0, PROF_AUTO, 1, 0));
    repeat (5) send_item(eval_item(15, 1, 0));
    // an ok reading clears the short count
    send_item(write_item(9, 700, 850, 100, PROF_INSTANT, 1, 0));
    repeat (2) send_item(eval_item(9, 1, 50));
    send_item(eval_item(9, 1, 400));
    repeat (2) send_item(eval_item(9, 1, 50));
    // excluded profile, delayed profile with bypass written, all-zero thresholds
    send_item(write_item(3, 0, 0, 1023, PROF_EXCLUDED, 0, 0));
    send_item(eval_item(3, 1, 0));
    send_item(write_item(5, 1000, 1000, 1000, PROF_DELAYED, 0, 1));
    send_item(eval_item(5, 1, 1000));
    send_item(write_item(7, 0, 0, 0, PROF_INSTANT, 0, 0));
    send_item(eval_item(7, 1, 1));
    wait_drained();

    // random phases; between phases the sender holds off until every owed result has been checked
    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 106; k++) begin
        sender_gap(idle_pct[ph]);
        z = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(ZONES - 1);
        pick = $urandom_range(99);
        if (burst_left > 0) begin
          it = eval_item(burst_zone, 1, ($urandom_range(1) != 0) ? 0 : $urandom_range(60));
          burst_left--;
        end else if (pick < 10) begin
          if ($urandom_range(99) < 80)
            it = write_item(z, $urandom_range(500, 800), $urandom_range(800, 1023),
                            $urandom_range(60, 200), profile_e'($urandom_range(3)),
                            $urandom_range(99) < 60, $urandom_range(99) < 15);
          else
            it = write_item(z, $urandom_range(1023), $urandom_range(1023),
                            $urandom_range(1023), profile_e'($urandom_range(3)),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
        end else if (pick < 18) begin
          // run of shorts on one zone
          burst_zone = z;
          burst_left = $urandom_range(3, 6);
          it = eval_item(z, 1, 0);
        end else begin
          pick = $urandom_range(99);
          if (pick < 35)      it = eval_item(z, 1, $urandom_range(150));
          else if (pick < 55) it = eval_item(z, 1, $urandom_range(600, 1023));
          else if (pick < 65) it = eval_item(z, 1, $urandom_range(1001, 1023));
          else if (pick < 92) it = eval_item(z, 1, $urandom_range(1000));
          else                it = eval_item(z, 0, $urandom_range(1023));
        end
        send_item(it);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d transactions (%0d zone writes, %0d invalid samples), %0d results checked",
             sb.n_items, sb.n_writes, sb.n_faults, sb.n_checked);
    $display("bypass latched by short runs %0d times; %0d mismatches, %0d results outstanding",
             sb.n_latches, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("alarm_zone_line_classifier_top_tb: done, clean");
    else
      $display("alarm_zone_line_classifier_top_tb: done, errors");
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("alarm_zone_line_classifier_top_tb: done, errors");
    $finish;
  end

endmodule
